// ----- sv/bffa_pkg.sv -----
package bffa_pkg;

    // Fixed field widths of the item and result
    localparam int SIZE_W      = 20;
    localparam int ADDR_W      = 32;
    // Block count before range checks: (2^20 - 1 + 65535) / 1 fits in 21 bits
    localparam int NEED_W      = 21;
    localparam int BITS_PER_BYTE = 8;

    // Stream payload widths
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 32;

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam logic [PADDR_W-3:0] REG_BASE_ADDRESS = 1'b0;
    localparam logic [ADDR_W-1:0]  BASE_RESET       = 32'h0100_0000;

    // Default sizing
    localparam int MAP_BYTES_DEF   = 512;
    localparam int BLOCK_BYTES_DEF = 128;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

endpackage

// ----- sv/bitmap_first_fit_block_allocator.sv -----
// First-fit block allocator over a one-bit-per-block occupancy map held in a
// MAP_BYTES x 8 synchronous RAM; block n of BLOCK_BYTES bytes is bit n%8 of
// map byte n/8 and starts at base_address + n*BLOCK_BYTES. An allocate item
// (tuser 0) rounds size_bytes up to blocks, takes the lowest free run of that
// length, marks it used and answers its address with ok set; a free item
// (tuser 1) clears the run starting at the block holding address, clipped to
// the pool. Zero size, no room, an address below base or a start past the
// pool answer ok 0 and address 0. After reset the map is swept clear byte by
// byte before the first item is taken. One item is worked on at a time: the
// size is rounded up to blocks (reciprocal multiply), for a free a second
// division finds the start block, then an allocate scans the map byte by
// byte up to the end of the found run, and the run is marked or cleared
// byte by byte, each byte read while the one before it is written back,
// before the answer is formed. A finished result waits in the output
// register while the next item is taken.
module bitmap_first_fit_block_allocator
    import bffa_pkg::*;
#(
    parameter int MAP_BYTES   = MAP_BYTES_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request items
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // size_bytes[19:0], address[51:20], zero pad
    input  logic                i_s_tuser,  // op
    // result items
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // result_address[31:0]
    output logic                o_m_tuser,  // ok
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int MA_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    logic [ADDR_W-1:0]        r_base;

    logic                     div_start;
    logic [ADDR_W-1:0]        div_dividend;
    logic                     div_done;
    logic [ADDR_W-1:0]        div_quot;
    logic                     mem_we;
    logic [MA_W-1:0]          mem_waddr;
    logic [BITS_PER_BYTE-1:0] mem_wdata;
    logic [MA_W-1:0]          mem_raddr;
    logic [BITS_PER_BYTE-1:0] mem_rdata;
    logic                     base_sel;

    // Base address register
    assign base_sel = (paddr[PADDR_W-1:2] == REG_BASE_ADDRESS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (psel && penable && pwrite && base_sel) begin
            r_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = base_sel ? r_base : '0;

    bffa_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    bffa_map_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (MA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bffa_ctrl #(
        .MAP_BYTES   (MAP_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MA_W        (MA_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_tvalid),
        .o_in_ready     (o_s_tready),
        .i_op           (t_op'(i_s_tuser)),
        .i_size         (i_s_tdata[SIZE_W-1:0]),
        .i_addr         (i_s_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
        .i_base         (r_base),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_out_addr     (o_m_tdata),
        .o_out_ok       (o_m_tuser)
    );

endmodule

// ----- sv/bffa_div.sv -----
// Division by a fixed divisor: multiply by a rounded-up reciprocal and shift.
// With SH = clog2(DIVISOR) and RECIP = ceil(2^(ADDR_W+SH) / DIVISOR), the top
// bits of dividend * RECIP give the exact quotient for every 32-bit dividend.
// RECIP needs ADDR_W+1 bits and is split into a 16-bit low half and a high
// half, so that each product stays near 32 x 16 bits. The quotient is
// registered after capture and multiply stages; o_done is high for one cycle.
module bffa_div
    import bffa_pkg::*;
#(
    parameter int DIVISOR = BLOCK_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_quotient
);

    localparam int SH    = $clog2(DIVISOR);
    localparam int PW    = 2 * ADDR_W + 1;
    localparam int LO_W  = 16;
    localparam int HI_W  = ADDR_W + 1 - LO_W;
    localparam int PLO_W = ADDR_W + LO_W;
    localparam int PHI_W = ADDR_W + HI_W;

    localparam logic [PW-1:0]   RECIP    = ((PW'(1) << (ADDR_W + SH)) + PW'(DIVISOR - 1))
                                           / PW'(DIVISOR);
    localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [HI_W-1:0] RECIP_HI = RECIP[ADDR_W:LO_W];

    logic [ADDR_W-1:0] r_dvd;
    logic [PLO_W-1:0]  r_plo;
    logic [PHI_W-1:0]  r_phi;
    logic [ADDR_W-1:0] r_quot;
    logic              r_mul_v;
    logic              r_sum_v;
    logic              r_done;

    logic [PW-1:0]     prod;

    // Recombine the two partial products
    assign prod = (PW'(r_phi) << LO_W) + PW'(r_plo);

    // Stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
            r_sum_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_mul_v <= i_start;
            r_sum_v <= r_mul_v;
            r_done  <= r_sum_v;
        end
    end

    // Capture, multiply, shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
        end
        if (r_mul_v) begin
            r_plo <= PLO_W'(r_dvd) * PLO_W'(RECIP_LO);
            r_phi <= PHI_W'(r_dvd) * PHI_W'(RECIP_HI);
        end
        if (r_sum_v) begin
            r_quot <= ADDR_W'(prod >> (ADDR_W + SH));
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// ----- sv/bffa_map_ram.sv -----
// Occupancy map: one write port, one registered read port
module bffa_map_ram
    import bffa_pkg::*;
#(
    parameter int DEPTH = MAP_BYTES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [BITS_PER_BYTE-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [BITS_PER_BYTE-1:0] o_rdata
);

    logic [BITS_PER_BYTE-1:0] r_mem [DEPTH];
    logic [BITS_PER_BYTE-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bffa_ctrl.sv -----
// Request sequencer: clear pass, size/offset division, map scan, run marking
module bffa_ctrl
    import bffa_pkg::*;
#(
    parameter int MAP_BYTES   = MAP_BYTES_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int MA_W        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_op                      i_op,
    input  logic [SIZE_W-1:0]        i_size,
    input  logic [ADDR_W-1:0]        i_addr,
    input  logic [ADDR_W-1:0]        i_base,
    // divider
    output logic                     o_div_start,
    output logic [ADDR_W-1:0]        o_div_dividend,
    input  logic                     i_div_done,
    input  logic [ADDR_W-1:0]        i_div_quot,
    // map memory
    output logic                     o_mem_we,
    output logic [MA_W-1:0]          o_mem_waddr,
    output logic [BITS_PER_BYTE-1:0] o_mem_wdata,
    output logic [MA_W-1:0]          o_mem_raddr,
    input  logic [BITS_PER_BYTE-1:0] i_mem_rdata,
    // result
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ADDR_W-1:0]        o_out_addr,
    output logic                     o_out_ok
);

    localparam int TOTAL  = MAP_BYTES * BITS_PER_BYTE;
    localparam int BI_W   = MA_W + 3;
    localparam int BN_W   = $clog2(TOTAL + 1);
    localparam int CNT_W  = $clog2(MAP_BYTES + 1);
    localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
    localparam int PROD_W = BI_W + BB_W;
    localparam int HI_W   = NEED_W + 1;

    localparam logic [MA_W-1:0]  LAST_BYTE = MA_W'(MAP_BYTES - 1);
    localparam logic [CNT_W-1:0] MAP_CNT   = CNT_W'(MAP_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_NEED,
        S_DIV_FIRST,
        S_SCAN,
        S_MARK,
        S_MUL,
        S_SUM,
        S_DONE
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic [NEED_W-1:0]   r_need_full;
    logic [BN_W-1:0]     r_need;
    logic [BN_W-1:0]     r_run;
    logic [BI_W-1:0]     r_start;
    logic [BI_W-1:0]     r_lo;
    logic [BI_W-1:0]     r_hi;
    logic [CNT_W-1:0]    r_ptr;
    logic                r_pv;
    logic [MA_W-1:0]     r_pbyte;
    logic                r_issue;
    logic [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_res_addr;
    logic                r_res_ok;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_ok;

    logic                in_acc;
    logic                free_go;
    logic [NEED_W-1:0]   need_q;
    logic [HI_W-1:0]     free_hi;
    logic [BI_W-1:0]     free_hi_cl;
    logic [BN_W-1:0]     s_run;
    logic [BI_W-1:0]     s_start;
    logic [BI_W-1:0]     s_blk;
    logic                s_found;
    logic [BI_W:0]       s_hi;
    logic [BI_W-1:0]     m_blk;
    logic [BITS_PER_BYTE-1:0] m_mask;
    logic [MA_W-1:0]     hi_byte;

    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign need_q  = i_div_quot[NEED_W-1:0];
    assign free_go = (r_state == S_DIV_NEED) && i_div_done && (r_op == OP_FREE)
                     && (r_addr >= i_base);
    assign hi_byte = r_hi[BI_W-1:3];

    // Divider requests: block count, then start block of a free
    assign o_div_start    = (in_acc && (i_size != '0)) || free_go;
    assign o_div_dividend = (r_state == S_IDLE)
                          ? (ADDR_W'(i_size) + ADDR_W'(BLOCK_BYTES - 1))
                          : (r_addr - i_base);

    // Last block of a free, clipped to the pool
    always_comb begin
        free_hi = HI_W'(i_div_quot[BI_W-1:0]) + HI_W'(r_need_full) - 1'b1;
        if (free_hi > HI_W'(TOTAL - 1)) begin
            free_hi_cl = BI_W'(TOTAL - 1);
        end else begin
            free_hi_cl = free_hi[BI_W-1:0];
        end
    end

    // Run search across the eight blocks of one map byte
    always_comb begin
        s_run   = r_run;
        s_start = r_start;
        s_found = 1'b0;
        s_blk   = '0;
        for (int b = 0; b < BITS_PER_BYTE; b++) begin
            s_blk = {r_pbyte, 3'(b)};
            if (!s_found) begin
                if (i_mem_rdata[b]) begin
                    s_run = '0;
                end else begin
                    if (s_run == '0) begin
                        s_start = s_blk;
                    end
                    s_run = s_run + 1'b1;
                    if (s_run >= r_need) begin
                        s_found = 1'b1;
                    end
                end
            end
        end
        s_hi = (BI_W + 1)'(s_start) + (BI_W + 1)'(r_need) - 1'b1;
    end

    // Bits of the current byte that fall inside [lo, hi]
    always_comb begin
        m_blk = '0;
        for (int b = 0; b < BITS_PER_BYTE; b++) begin
            m_blk     = {r_pbyte, 3'(b)};
            m_mask[b] = (m_blk >= r_lo) && (m_blk <= r_hi);
        end
    end

    // Memory ports
    assign o_mem_we    = (r_state == S_CLEAR) || ((r_state == S_MARK) && r_pv);
    assign o_mem_waddr = (r_state == S_CLEAR) ? r_ptr[MA_W-1:0] : r_pbyte;
    assign o_mem_wdata = (r_state == S_CLEAR) ? '0
                       : (r_op == OP_ALLOC) ? (i_mem_rdata | m_mask)
                       : (i_mem_rdata & ~m_mask);
    assign o_mem_raddr = r_ptr[MA_W-1:0];

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_pv        <= 1'b0;
            r_issue     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr[MA_W-1:0] == LAST_BYTE) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_op;
                        r_addr <= i_addr;
                        if (i_size == '0) begin
                            r_res_addr <= '0;
                            r_res_ok   <= 1'b0;
                            r_state    <= S_DONE;
                        end else begin
                            r_state <= S_DIV_NEED;
                        end
                    end
                end
                S_DIV_NEED: begin
                    if (i_div_done) begin
                        r_need_full <= need_q;
                        r_need      <= BN_W'(need_q);
                        r_res_addr  <= '0;
                        r_res_ok    <= 1'b0;
                        if (r_op == OP_ALLOC) begin
                            if (need_q > NEED_W'(TOTAL)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_ptr   <= '0;
                                r_pv    <= 1'b0;
                                r_run   <= '0;
                                r_start <= '0;
                                r_state <= S_SCAN;
                            end
                        end else if (free_go) begin
                            r_state <= S_DIV_FIRST;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV_FIRST: begin
                    if (i_div_done) begin
                        if (i_div_quot >= ADDR_W'(TOTAL)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_lo    <= i_div_quot[BI_W-1:0];
                            r_hi    <= free_hi_cl;
                            r_ptr   <= CNT_W'(i_div_quot[BI_W-1:3]);
                            r_issue <= 1'b1;
                            r_pv    <= 1'b0;
                            r_state <= S_MARK;
                        end
                    end
                end
                S_SCAN: begin
                    // one byte read a cycle, processed when it returns
                    r_pv    <= (r_ptr < MAP_CNT);
                    r_pbyte <= r_ptr[MA_W-1:0];
                    if (r_ptr < MAP_CNT) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (r_pv) begin
                        r_run   <= s_run;
                        r_start <= s_start;
                        if (s_found) begin
                            r_lo    <= s_start;
                            r_hi    <= s_hi[BI_W-1:0];
                            r_ptr   <= CNT_W'(s_start[BI_W-1:3]);
                            r_issue <= 1'b1;
                            r_pv    <= 1'b0;
                            r_state <= S_MARK;
                        end else if (r_pbyte == LAST_BYTE) begin
                            r_pv    <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MARK: begin
                    // read byte k+1 while byte k is written back
                    r_pv    <= r_issue;
                    r_pbyte <= r_ptr[MA_W-1:0];
                    if (r_issue) begin
                        if (r_ptr[MA_W-1:0] == hi_byte) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_ptr <= r_ptr + 1'b1;
                        end
                    end
                    if (r_pv && (r_pbyte == hi_byte)) begin
                        r_pv <= 1'b0;
                        if (r_op == OP_ALLOC) begin
                            r_state <= S_MUL;
                        end else begin
                            r_res_addr <= '0;
                            r_res_ok   <= 1'b1;
                            r_state    <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_lo) * PROD_W'(BLOCK_BYTES);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_res_addr <= i_base + ADDR_W'(r_prod);
                    r_res_ok   <= 1'b1;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_addr  <= r_res_addr;
                        r_out_ok    <= r_res_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_addr  = r_out_addr;
    assign o_out_ok    = r_out_ok;

endmodule

// ----- sv/bffa_checker.sv -----
// Port-level checks for the allocator
module bffa_checker
    import bffa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                o_m_tuser
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_outst;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    // Items taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 2'(in_acc) - 2'(out_acc);
        end
    end

    // Nothing taken or shown straight after reset (map clear in progress)
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("item handshake open right after reset");

    // Every result answers an earlier item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_outst != 2'd0)
        else $error("result without a pending item");

    // At most one item in work and one result waiting
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst != 2'd3)
        else $error("too many items in flight");

    // A failed request reports address zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("failed result carries an address");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind bitmap_first_fit_block_allocator bffa_checker u_bffa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- test/tb_bitmap_first_fit_block_allocator.sv -----
`timescale 1ns / 1ps

module tb_bitmap_first_fit_block_allocator;
    import bffa_pkg::*;

    localparam int MAP_BYTES    = MAP_BYTES_DEF;
    localparam int BLOCK_BYTES  = BLOCK_BYTES_DEF;
    localparam int TOTAL_BLOCKS = MAP_BYTES * BITS_PER_BYTE;
    localparam int MAX_SIZE     = 524288;
    localparam int MAX_IDLE     = 13;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 40;
    localparam int STALL_CYCLES = 3000;
    localparam int PHASE_ITEMS  = 200;

    localparam logic [PADDR_W-1:0] OFFS_BASE_ADDRESS = {REG_BASE_ADDRESS, 2'b00};
    localparam logic [PADDR_W-1:0] OFFS_UNMAPPED     = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              ok;
    } t_answer;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } t_run;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;   // size_bytes[19:0], address[51:20], zero pad
    logic                i_s_tuser;   // op
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;   // result_address[31:0]
    logic                o_m_tuser;   // ok
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predictor state: own copy of the occupancy map and base register
    bit                block_busy [TOTAL_BLOCKS];
    logic [ADDR_W-1:0] base_copy;

    t_answer expected_answers [$];
    t_run    live_runs [$];

    bit src_idle_on;
    bit sink_idle_on;
    int sink_hold_cycles;

    int error_count;
    int cycle_count;
    int results_checked;
    int allocs_granted;
    int allocs_refused;
    int frees_done;
    int frees_refused;
    int base_settings;

    bitmap_first_fit_block_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // First-fit allocator behaviour; updates the map copy and gives the answer
    function automatic t_answer compute_answer(input t_op op, input logic [SIZE_W-1:0] size_b,
                                               input logic [ADDR_W-1:0] addr);
        t_answer     ans;
        int unsigned need;
        int unsigned run_len;
        int unsigned run_start;
        int unsigned first;
        ans       = '0;
        run_len   = 0;
        run_start = 0;
        if (size_b == '0)
            return ans;
        need = (32'(size_b) + BLOCK_BYTES - 1) / BLOCK_BYTES;

        if (op == OP_ALLOC) begin
            if (need > TOTAL_BLOCKS)
                return ans;
            for (int n = 0; n < TOTAL_BLOCKS; n++) begin
                if (block_busy[n]) begin
                    run_len = 0;
                end else begin
                    if (run_len == 0)
                        run_start = n;
                    run_len++;
                    if (run_len >= need) begin
                        for (int k = 0; k < need; k++)
                            block_busy[run_start + k] = 1'b1;
                        ans.addr = base_copy + ADDR_W'(run_start * BLOCK_BYTES);
                        ans.ok   = 1'b1;
                        return ans;
                    end
                end
            end
            return ans;
        end

        // free: start block rounded down, run clipped at the pool end
        if (addr < base_copy)
            return ans;
        first = (addr - base_copy) / BLOCK_BYTES;
        if (first >= TOTAL_BLOCKS)
            return ans;
        for (int k = 0; k < need && first + k < TOTAL_BLOCKS; k++)
            block_busy[first + k] = 1'b0;
        ans.ok = 1'b1;
        return ans;
    endfunction

    // Offer one request item and predict its answer once accepted
    task automatic send_request(input t_op op, input logic [SIZE_W-1:0] size_b,
                                input logic [ADDR_W-1:0] addr, output t_answer ans);
        int   gap;
        t_run run;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W - SIZE_W - ADDR_W){1'b0}}, addr, size_b};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);

        ans = compute_answer(op, size_b, addr);
        expected_answers.push_back(ans);
        if (op == OP_ALLOC) begin
            if (ans.ok) begin
                allocs_granted++;
                run.first = (ans.addr - base_copy) / BLOCK_BYTES;
                run.count = (32'(size_b) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                live_runs.push_back(run);
            end else begin
                allocs_refused++;
            end
        end else begin
            if (ans.ok)
                frees_done++;
            else
                frees_refused++;
        end
    endtask

    // Let every outstanding answer come back
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_base_register();
        logic [PDATA_W-1:0] rd;
        apb_read(OFFS_BASE_ADDRESS, rd);
        if (rd !== base_copy) begin
            $error("base_address readback: expected %h, actual %h", base_copy, rd);
            error_count++;
        end
    endtask

    // Registers change only with the block idle
    task automatic set_base(input logic [ADDR_W-1:0] value);
        wait_idle();
        apb_write(OFFS_BASE_ADDRESS, value);
        base_copy = value;
        base_settings++;
        check_base_register();
    endtask

    // Answer checker: oldest expectation against each accepted result item
    always @(posedge i_clk) begin : check_results
        t_answer want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected result item: result_address %h ok %b", o_m_tdata, o_m_tuser);
                error_count++;
            end else begin
                want = expected_answers.pop_front();
                results_checked++;
                if (o_m_tdata !== want.addr) begin
                    $error("result_address: expected %h, actual %h", want.addr, o_m_tdata);
                    error_count++;
                end
                if (o_m_tuser !== want.ok) begin
                    $error("ok: expected %b, actual %b", want.ok, o_m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Result receiver: random stalls per item, plus an optional long hold
    initial begin : result_sink
        int wait_n;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            wait_n = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (sink_hold_cycles > 0) begin
                wait_n           = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (wait_n > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic test_reset_value();
        check_base_register();
    endtask

    // Field extremes and each corner of the allocate and free rules
    task automatic test_special_cases();
        t_answer           ans;
        logic [ADDR_W-1:0] b;
        b = base_copy;
        send_request(OP_ALLOC, '0, b, ans);                    // zero size
        send_request(OP_FREE, '0, b, ans);
        send_request(OP_ALLOC, 1, 32'hFFFF_FFFF, ans);         // address ignored
        send_request(OP_ALLOC, BLOCK_BYTES, '0, ans);
        send_request(OP_ALLOC, BLOCK_BYTES + 1, '0, ans);      // rounds up to two blocks
        send_request(OP_ALLOC, MAX_SIZE, '0, ans);             // no room
        send_request(OP_FREE, BLOCK_BYTES, b - 1, ans);        // below base
        send_request(OP_FREE, 1, '0, ans);
        send_request(OP_FREE, 1, b + TOTAL_BLOCKS * BLOCK_BYTES, ans);  // past pool
        send_request(OP_FREE, MAX_SIZE, 32'hFFFF_FFFF, ans);
        send_request(OP_FREE, 1, b + BLOCK_BYTES + 77, ans);   // unaligned free
        send_request(OP_ALLOC, 100, '0, ans);                  // reuses the freed hole
        send_request(OP_FREE, 1024, b + (TOTAL_BLOCKS - 1) * BLOCK_BYTES + 5, ans);  // clipped
        send_request(OP_FREE, MAX_SIZE, b, ans);
        send_request(OP_ALLOC, MAX_SIZE, '0, ans);             // whole pool
        send_request(OP_ALLOC, 1, '0, ans);
        send_request(OP_FREE, MAX_SIZE - 1, b, ans);
        send_request(OP_ALLOC, MAX_SIZE - 1, '0, ans);
        send_request(OP_FREE, MAX_SIZE, b, ans);
    endtask

    // Base register extremes, address wrap and the unmapped register
    task automatic test_base_extremes();
        t_answer ans;
        set_base('0);
        send_request(OP_ALLOC, 1, '0, ans);
        send_request(OP_FREE, 1, '0, ans);
        set_base(32'hFFFF_FFFF);
        send_request(OP_ALLOC, 1, '0, ans);
        send_request(OP_ALLOC, 1, '0, ans);                    // wraps past zero
        send_request(OP_FREE, 1, 32'h0000_007F, ans);          // below base after wrap
        send_request(OP_FREE, 2 * BLOCK_BYTES, 32'hFFFF_FFFF, ans);
        wait_idle();
        apb_write(OFFS_UNMAPPED, $urandom());
        check_base_register();
        send_request(OP_ALLOC, 1, '0, ans);
        send_request(OP_FREE, BLOCK_BYTES, 32'hFFFF_FFFF, ans);
        set_base(32'hFFFF_F000);
        send_request(OP_ALLOC, 40 * BLOCK_BYTES, '0, ans);
        send_request(OP_ALLOC, 1, '0, ans);
        send_request(OP_FREE, MAX_SIZE, 32'hFFFF_F000, ans);
    endtask

    // Full map with a full scan, single-block holes and first-fit skipping
    task automatic test_fill_and_drain();
        t_answer           ans;
        logic [ADDR_W-1:0] b;
        set_base($urandom_range(0, 32'h7FFF_FFFF));
        b = base_copy;
        send_request(OP_ALLOC, MAX_SIZE / 2, '0, ans);
        send_request(OP_ALLOC, MAX_SIZE / 2, '0, ans);
        send_request(OP_ALLOC, 1, '0, ans);
        send_request(OP_FREE, 1, b + 1000 * BLOCK_BYTES, ans);
        send_request(OP_ALLOC, BLOCK_BYTES, '0, ans);
        send_request(OP_FREE, MAX_SIZE, b, ans);
        repeat (3) send_request(OP_ALLOC, 5 * BLOCK_BYTES, '0, ans);
        send_request(OP_FREE, 5 * BLOCK_BYTES, b + 5 * BLOCK_BYTES, ans);
        send_request(OP_ALLOC, 6 * BLOCK_BYTES, '0, ans);      // hole too small
        send_request(OP_ALLOC, 600, '0, ans);                  // fits the hole
        send_request(OP_FREE, MAX_SIZE, b, ans);
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        t_answer ans;
        wait_idle();
        src_idle_on      = 1'b0;
        sink_hold_cycles = STALL_CYCLES;
        repeat (16) send_request(OP_ALLOC, $urandom_range(1, 4 * BLOCK_BYTES), '0, ans);
        send_request(OP_FREE, MAX_SIZE, base_copy, ans);
        src_idle_on = 1'b1;
    endtask

    // Mostly allocate/free pairs on live runs, with some noise, over several bases
    task automatic test_random_traffic();
        t_answer           ans;
        t_run              run;
        int                idx;
        int                pick;
        logic [SIZE_W-1:0] size_b;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] phase_base [4];
        phase_base[0] = $urandom();
        phase_base[1] = 32'hFFFF_C000;
        phase_base[2] = $urandom_range(0, 32'h00FF_FFFF);
        phase_base[3] = BASE_RESET;
        live_runs.delete();

        for (int p = 0; p < 4; p++) begin
            set_base(phase_base[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // stretches with and without idling on each side
                if (n % 40 == 0) begin
                    src_idle_on  = ($urandom_range(0, 3) != 0);
                    sink_idle_on = ($urandom_range(0, 3) != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    if (live_runs.size() != 0 &&
                        (live_runs.size() >= 24 || $urandom_range(0, 99) < 45)) begin
                        idx  = $urandom_range(0, live_runs.size() - 1);
                        run  = live_runs[idx];
                        live_runs.delete(idx);
                        size_b = run.count * BLOCK_BYTES - $urandom_range(0, BLOCK_BYTES - 1);
                        addr   = base_copy + run.first * BLOCK_BYTES
                                 + $urandom_range(0, BLOCK_BYTES - 1);
                        send_request(OP_FREE, size_b, addr, ans);
                    end else begin
                        size_b = ($urandom_range(0, 24) == 0) ? $urandom_range(1, MAX_SIZE)
                                                              : $urandom_range(1, 2048);
                        send_request(OP_ALLOC, size_b, $urandom(), ans);
                    end
                end else begin
                    case ($urandom_range(0, 3))
                        0: send_request(t_op'($urandom_range(0, 1)),
                                        $urandom_range(0, MAX_SIZE), $urandom(), ans);
                        1: send_request(t_op'($urandom_range(0, 1)), '0, $urandom(), ans);
                        2: begin
                            // free around the pool edges, partly overlapping live runs
                            addr = base_copy
                                   + $urandom_range(0, TOTAL_BLOCKS * BLOCK_BYTES + 4096) - 2048;
                            send_request(OP_FREE, $urandom_range(1, 8192), addr, ans);
                        end
                        default: send_request(OP_ALLOC, $urandom_range(1, 16 * BLOCK_BYTES),
                                              $urandom(), ans);
                    endcase
                end
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= OP_ALLOC;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cycle_count      = 0;
        error_count      = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        sink_hold_cycles = 0;
        base_copy        = BASE_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_value();
        test_special_cases();
        test_base_extremes();
        test_fill_and_drain();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        $display("Allocations: %0d granted, %0d refused; frees: %0d done, %0d refused",
                 allocs_granted, allocs_refused, frees_done, frees_refused);
        $display("%0d answers checked across %0d base settings, incl. a %0d-cycle output stall",
                 results_checked, base_settings, STALL_CYCLES);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/bffa_pkg.sv
sv/bffa_div.sv
sv/bffa_map_ram.sv
sv/bffa_ctrl.sv
sv/bitmap_first_fit_block_allocator.sv
sv/bffa_checker.sv
test/tb_bitmap_first_fit_block_allocator.sv
